// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bur_pkg.sv
// shared constants and types for the bounded undo/redo history block
package bur_pkg;

    localparam int RING_DEPTH_DEF   = 128;
    localparam int ACTION_WIDTH_DEF = 32;

    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int MAX_W    = 8;

    localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 8'd128;

    localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
    localparam logic [OP_W-1:0] OP_UNDO      = 3'd1;
    localparam logic [OP_W-1:0] OP_REDO      = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK      = 3'd3;
    localparam logic [OP_W-1:0] OP_CLR_ALL   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLR_REDO  = 3'd5;

    typedef struct packed {
        logic accept;    // item taken this cycle, execute it
        logic load_out;  // move the finished item into the output register
    } ctrl_cmd_t;

endpackage

// File: hw/rtl/bur_ram.sv
// generic single write port, single read port ram with registered read
module bur_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/bur_ctrl.sv
// controller: sequences accept, ring read and output register load
module bur_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output bur_pkg::ctrl_cmd_t cmd
);
    import bur_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_RESULT = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // ring read data is ready now; wait for room at the output
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: hw/rtl/bur_datapath.sv
// datapath: ring pointers, stack counts, limit register, ring memory and output register
module bur_datapath #(
    parameter int RING_DEPTH   = bur_pkg::RING_DEPTH_DEF,
    parameter int ACTION_WIDTH = bur_pkg::ACTION_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bur_pkg::ctrl_cmd_t          cmd,
    input  logic [bur_pkg::OP_W-1:0]    s_op,
    input  logic [bur_pkg::WORD_W-1:0]  s_action_in,
    input  logic                        cfg_wr_en,
    input  logic [bur_pkg::MAX_W-1:0]   cfg_wr_data,
    output logic                        m_ok,
    output logic [bur_pkg::WORD_W-1:0]  m_action_out,
    output logic [bur_pkg::COUNT_W-1:0] m_undo_count,
    output logic [bur_pkg::COUNT_W-1:0] m_redo_count
);
    import bur_pkg::*;

    localparam int AD = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int XW = (CW + 1 > MAX_W) ? CW + 1 : MAX_W;
    localparam logic [CW:0]   DEPTH_S   = (CW + 1)'(RING_DEPTH);
    localparam logic [XW-1:0] DEPTH_X   = XW'(RING_DEPTH);
    localparam logic [AD-1:0] LAST_SLOT = AD'(RING_DEPTH - 1);

    logic [AD-1:0] base_reg, base_next;
    logic [CW-1:0] undo_reg, undo_next;
    logic [CW-1:0] redo_reg, redo_next;
    logic [MAX_W-1:0] max_reg;
    logic pend_ok_reg, pend_ok_next;
    logic pend_rd_reg, pend_rd_next;

    logic          out_ok_reg;
    logic [WORD_W-1:0]  out_action_reg;
    logic [COUNT_W-1:0] out_undo_reg;
    logic [COUNT_W-1:0] out_redo_reg;

    logic [CW:0]   sum_top, sum_below;
    logic [CW-1:0] undo_dec;
    logic [AD-1:0] slot_top, slot_below, base_inc;
    logic [XW-1:0] max_x, lim_x, undo_inc_x;

    logic                    ram_we, ram_re;
    logic [AD-1:0]           ram_raddr;
    logic [ACTION_WIDTH-1:0] ram_wdata, ram_rdata;

    // ring slots at the stack boundary and just below it
    always_comb begin
        undo_dec  = undo_reg - 1'b1;
        sum_top   = (CW + 1)'(base_reg) + (CW + 1)'(undo_reg);
        sum_below = (CW + 1)'(base_reg) + (CW + 1)'(undo_dec);
        if (sum_top >= DEPTH_S) begin
            sum_top = sum_top - DEPTH_S;
        end
        if (sum_below >= DEPTH_S) begin
            sum_below = sum_below - DEPTH_S;
        end
        slot_top   = sum_top[AD-1:0];
        slot_below = sum_below[AD-1:0];
        base_inc   = (base_reg == LAST_SLOT) ? '0 : base_reg + 1'b1;
    end

    // limit clamped to 1 .. ring depth
    always_comb begin
        max_x = XW'(max_reg);
        if (max_x == '0) begin
            lim_x = XW'(1);
        end else if (max_x > DEPTH_X) begin
            lim_x = DEPTH_X;
        end else begin
            lim_x = max_x;
        end
        undo_inc_x = XW'(undo_reg) + XW'(1);
    end

    assign ram_wdata = ACTION_WIDTH'(s_action_in);

    always_comb begin
        base_next    = base_reg;
        undo_next    = undo_reg;
        redo_next    = redo_reg;
        pend_ok_next = pend_ok_reg;
        pend_rd_next = pend_rd_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = slot_top;
        if (cmd.accept) begin
            pend_ok_next = 1'b0;
            pend_rd_next = 1'b0;
            case (s_op)
                OP_PUSH: begin
                    ram_we       = 1'b1;
                    redo_next    = '0;
                    pend_ok_next = 1'b1;
                    // over the limit: drop the oldest item, count stays
                    if (undo_inc_x > lim_x) begin
                        base_next = base_inc;
                    end else begin
                        undo_next = undo_reg + 1'b1;
                    end
                end
                OP_UNDO: begin
                    if (undo_reg != '0) begin
                        ram_re       = 1'b1;
                        ram_raddr    = slot_below;
                        undo_next    = undo_dec;
                        redo_next    = redo_reg + 1'b1;
                        pend_ok_next = 1'b1;
                        pend_rd_next = 1'b1;
                    end
                end
                OP_REDO: begin
                    if (redo_reg != '0) begin
                        ram_re       = 1'b1;
                        ram_raddr    = slot_top;
                        undo_next    = undo_reg + 1'b1;
                        redo_next    = redo_reg - 1'b1;
                        pend_ok_next = 1'b1;
                        pend_rd_next = 1'b1;
                    end
                end
                OP_PEEK: begin
                    if (undo_reg != '0) begin
                        ram_re       = 1'b1;
                        ram_raddr    = slot_below;
                        pend_ok_next = 1'b1;
                        pend_rd_next = 1'b1;
                    end
                end
                OP_CLR_ALL: begin
                    undo_next    = '0;
                    redo_next    = '0;
                    pend_ok_next = 1'b1;
                end
                OP_CLR_REDO: begin
                    redo_next    = '0;
                    pend_ok_next = 1'b1;
                end
                default: begin
                    pend_ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            undo_reg    <= '0;
            redo_reg    <= '0;
            max_reg     <= MAX_ENTRIES_RST;
            pend_ok_reg <= 1'b0;
            pend_rd_reg <= 1'b0;
        end else begin
            base_reg    <= base_next;
            undo_reg    <= undo_next;
            redo_reg    <= redo_next;
            pend_ok_reg <= pend_ok_next;
            pend_rd_reg <= pend_rd_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    // counts were updated at accept, so they already show the item's outcome
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_ok_reg     <= pend_ok_reg;
            out_action_reg <= pend_rd_reg ? WORD_W'(ram_rdata) : '0;
            out_undo_reg   <= COUNT_W'(undo_reg);
            out_redo_reg   <= COUNT_W'(redo_reg);
        end
    end

    bur_ram #(
        .WIDTH (ACTION_WIDTH),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_top),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_ok         = out_ok_reg;
    assign m_action_out = out_action_reg;
    assign m_undo_count = out_undo_reg;
    assign m_redo_count = out_redo_reg;

endmodule

// File: hw/rtl/bounded_undo_redo_stack_top.sv
// top level of the bounded undo/redo history block
// Keeps an undo stack and a redo stack of action words in one ring memory of
// RING_DEPTH entries. When an item is accepted the counts update and the ring
// is read into its registered output; the item then waits in the result state
// until the output register has room, and is loaded into it. No new item is
// accepted until the previous one is loaded, so a result held at the output
// stalls the next item and also acceptance of the item after it. The limit
// register max_reg (reset 128) is to be written with cfg_wr_en/cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
// Values of 0 act as 1 and values above RING_DEPTH act as RING_DEPTH. No
// clearing pass is needed after reset: ring entries are only read once written.
module bounded_undo_redo_stack_top #(
    parameter int RING_DEPTH   = bur_pkg::RING_DEPTH_DEF,
    parameter int ACTION_WIDTH = bur_pkg::ACTION_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bur_pkg::OP_W-1:0]    s_op,
    input  logic [bur_pkg::WORD_W-1:0]  s_action_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_ok,
    output logic [bur_pkg::WORD_W-1:0]  m_action_out,
    output logic [bur_pkg::COUNT_W-1:0] m_undo_count,
    output logic [bur_pkg::COUNT_W-1:0] m_redo_count,
    input  logic                        cfg_wr_en,
    input  logic [bur_pkg::MAX_W-1:0]   cfg_wr_data
);
    import bur_pkg::*;

    ctrl_cmd_t cmd;

    bur_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    bur_datapath #(
        .RING_DEPTH   (RING_DEPTH),
        .ACTION_WIDTH (ACTION_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_op         (s_op),
        .s_action_in  (s_action_in),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .m_ok         (m_ok),
        .m_action_out (m_action_out),
        .m_undo_count (m_undo_count),
        .m_redo_count (m_redo_count)
    );

endmodule

// File: hw/rtl/bur_checker.sv
// port-level checks for the bounded undo/redo history block, with bind
`include "assert_macros.svh"

module bur_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_ok,
    input logic [bur_pkg::WORD_W-1:0]  m_action_out,
    input logic [bur_pkg::COUNT_W-1:0] m_undo_count,
    input logic [bur_pkg::COUNT_W-1:0] m_redo_count
);
    import bur_pkg::*;

    // a stalled result keeps its contents
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_ok) && $stable(m_action_out) && $stable(m_undo_count) && $stable(m_redo_count), "stalled result changed")

    // a failed lookup returns a zero word
    `ASSERT_CLK(a_fail_zero, aclk, aresetn, m_valid && !m_ok |-> m_action_out == '0, "failed item carries a word")

    // one item in flight: no acceptance in the cycle after one
    `ASSERT_CLK(a_one_in_flight, aclk, aresetn, s_valid && s_ready |=> !s_ready, "second item accepted back to back")

    // reset leaves no result on the output
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind bounded_undo_redo_stack_top bur_checker u_bur_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_ok         (m_ok),
    .m_action_out (m_action_out),
    .m_undo_count (m_undo_count),
    .m_redo_count (m_redo_count)
);
